// ===== sv/dpsc_pkg.sv =====
// dpsc_pkg: shared constants, codes and types of the diverse point set checker
// depends on nothing; imported by dpsc_isqrt and diverse_point_set_checker
package dpsc_pkg;

    localparam int STORE_DEPTH_DEF = 32;

    localparam int AXIS_W   = 16;
    localparam int CNT_W    = 7;
    localparam int VIOL_W   = 16;
    localparam int DIST_W   = 34;
    localparam int ROOT_W   = 17;
    localparam int SUM_W    = 23;
    localparam int SUMSQ_W  = 40;
    localparam int LHS_W    = 47;
    localparam int MUL_A_W  = 40;
    localparam int MUL_B_W  = 23;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int CFG_W    = 34;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W    = 3;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_QUALITY = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [OUT_W-1:0] OUT_NONE      = 3'd0;
    localparam logic [OUT_W-1:0] OUT_STORED    = 3'd1;
    localparam logic [OUT_W-1:0] OUT_TOO_CLOSE = 3'd2;
    localparam logic [OUT_W-1:0] OUT_TOO_FAR   = 3'd3;
    localparam logic [OUT_W-1:0] OUT_FULL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VIOL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT   = 3'd5;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ===== sv/diverse_point_set_checker.sv =====
// diverse_point_set_checker: one item at a time. Clear, unused, full-store, first-in-empty-store
// and ineligible quality commands go straight to the output state; a sample compares the item
// with each stored point in turn (one shared multiplier squares each axis in turn), and a quality
// query also takes the 17-step iterative square root of each squared distance to the query item.
// A finished result waits while the previous one is not taken; input is ready once it registers.
// Synchronous active-low reset clears counts, flags, limits (min points to 1), not point memory.
module diverse_point_set_checker #(
    parameter int STORE_DEPTH = dpsc_pkg::STORE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpsc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic signed [dpsc_pkg::AXIS_W-1:0] s_axis_x,
    input  logic signed [dpsc_pkg::AXIS_W-1:0] s_axis_y,
    input  logic signed [dpsc_pkg::AXIS_W-1:0] s_axis_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dpsc_pkg::OUT_W-1:0]        m_outcome,
    output logic                              m_quality_ok,
    output logic [dpsc_pkg::CNT_W-1:0]        m_stored_count,
    output logic [dpsc_pkg::VIOL_W-1:0]       m_violation_count,
    output logic                              m_store_full
);
    import dpsc_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PT_W = 3 * AXIS_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_ACC  = 4'd3;
    localparam logic [3:0] ST_EVAL = 4'd4;
    localparam logic [3:0] ST_SQW  = 4'd5;
    localparam logic [3:0] ST_NSQ  = 4'd6;
    localparam logic [3:0] ST_NACC = 4'd7;
    localparam logic [3:0] ST_F0   = 4'd8;
    localparam logic [3:0] ST_F1   = 4'd9;
    localparam logic [3:0] ST_F2   = 4'd10;
    localparam logic [3:0] ST_F3   = 4'd11;
    localparam logic [3:0] ST_F4   = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    // configuration
    logic [DIST_W-1:0] near_reg, far_reg;
    logic [CNT_W-1:0]  minp_reg;
    logic [VIOL_W-1:0] maxv_reg;
    logic [ROOT_W-1:0] spread_reg;
    logic [31:0]       varl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg   <= '0;
            far_reg    <= '0;
            minp_reg   <= CNT_W'(1);
            maxv_reg   <= '0;
            spread_reg <= '0;
            varl_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NEAR_LIMIT: near_reg   <= cfg_wr_data[DIST_W-1:0];
                REG_FAR_LIMIT:  far_reg    <= cfg_wr_data[DIST_W-1:0];
                REG_MIN_POINTS: minp_reg   <= cfg_wr_data[CNT_W-1:0];
                REG_MAX_VIOL:   maxv_reg   <= cfg_wr_data[VIOL_W-1:0];
                REG_SPREAD:     spread_reg <= cfg_wr_data[ROOT_W-1:0];
                REG_VAR_LIMIT:  varl_reg   <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    // point memory
    logic [PT_W-1:0] point_mem [STORE_DEPTH];
    logic [PT_W-1:0] rd_reg;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;

    // state
    logic [3:0]         state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [PT_W-1:0]    item_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [1:0]         ax_reg, ax_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [ROOT_W-1:0]  nm_reg, nm_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUMSQ_W-1:0] sumsq_reg, sumsq_next;
    logic [ROOT_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [LHS_W-1:0]   lhs_reg, lhs_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VIOL_W-1:0]  viol_reg, viol_next;
    logic               full_reg, full_next;
    logic [OUT_W-1:0]   res_out_reg, res_out_next;
    logic               res_ok_reg, res_ok_next;
    logic               m_valid_reg, m_valid_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic signed [AXIS_W:0] diff;
    logic [AXIS_W:0]    diff_abs;
    logic signed [AXIS_W-1:0] pa, pb;
    logic               last_pt;
    logic [CNT_W-1:0]   minp_eff;
    logic               accept;
    sqrt_req_t          sq_req;
    sqrt_rsp_t          sq_rsp;

    dpsc_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .rsp     (sq_rsp)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign minp_eff = (minp_reg == '0) ? CNT_W'(1) : minp_reg;
    assign last_pt  = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign wr_addr  = count_reg[AW-1:0];

    always_comb begin
        unique case (ax_reg)
            2'd0:    begin pa = rd_reg[AXIS_W-1:0];          pb = item_reg[AXIS_W-1:0]; end
            2'd1:    begin pa = rd_reg[2*AXIS_W-1:AXIS_W];   pb = item_reg[2*AXIS_W-1:AXIS_W]; end
            default: begin pa = rd_reg[PT_W-1:2*AXIS_W];     pb = item_reg[PT_W-1:2*AXIS_W]; end
        endcase
        diff     = {pa[AXIS_W-1], pa} - {pb[AXIS_W-1], pb};
        diff_abs = diff[AXIS_W] ? (AXIS_W+1)'(0) - diff : diff;
    end

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_MUL:  begin mul_a = MUL_A_W'(diff_abs);  mul_b = MUL_B_W'(diff_abs); end
            ST_NSQ:  begin mul_a = MUL_A_W'(nm_reg);    mul_b = MUL_B_W'(nm_reg); end
            ST_F0:   begin mul_a = sumsq_reg;           mul_b = MUL_B_W'(count_reg); end
            ST_F1:   begin mul_a = MUL_A_W'(sum_reg);   mul_b = sum_reg; end
            ST_F2:   begin mul_a = MUL_A_W'(varl_reg);  mul_b = MUL_B_W'(count_reg); end
            default: begin mul_a = prod_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(count_reg); end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ax_next      = ax_reg;
        dist_next    = dist_reg;
        nm_next      = nm_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        lhs_next     = lhs_reg;
        count_next   = count_reg;
        viol_next    = viol_reg;
        full_next    = full_reg;
        res_out_next = res_out_reg;
        res_ok_next  = res_ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_we       = 1'b0;
        sq_req.start    = 1'b0;
        sq_req.radicand = dist_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_out_next = OUT_NONE;
                    res_ok_next  = 1'b0;
                    idx_next     = '0;
                    sum_next     = '0;
                    sumsq_next   = '0;
                    state_next   = ST_FIN;
                    priority case (s_cmd)
                        CMD_SAMPLE: begin
                            if (full_reg) begin
                                res_out_next = OUT_FULL;
                            end else if (count_reg == '0) begin
                                mem_we       = 1'b1;
                                count_next   = CNT_W'(1);
                                full_next    = (STORE_DEPTH == 1);
                                res_out_next = OUT_STORED;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        CMD_QUALITY: begin
                            if (count_reg > minp_eff && viol_reg < maxv_reg) begin
                                state_next = ST_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                            viol_next  = '0;
                            full_next  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD: begin
                dist_next  = '0;
                ax_next    = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                dist_next = dist_reg + prod_reg[DIST_W-1:0];
                ax_next   = ax_reg + 2'd1;
                state_next = (ax_reg == 2'd2) ? ST_EVAL : ST_MUL;
            end
            ST_EVAL: begin
                if (cmd_reg == CMD_QUALITY) begin
                    sq_req.start = 1'b1;
                    state_next   = ST_SQW;
                end else if (dist_reg < near_reg) begin
                    res_out_next = OUT_TOO_CLOSE;
                    state_next   = ST_FIN;
                end else if (dist_reg > far_reg) begin
                    if (viol_reg != '1) viol_next = viol_reg + VIOL_W'(1);
                    res_out_next = OUT_TOO_FAR;
                    state_next   = ST_FIN;
                end else if (last_pt) begin
                    mem_we       = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                    full_next    = (count_reg + CNT_W'(1) == CNT_W'(STORE_DEPTH));
                    res_out_next = OUT_STORED;
                    state_next   = ST_FIN;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            ST_SQW: begin
                if (sq_rsp.done) begin
                    nm_next    = sq_rsp.root;
                    state_next = ST_NSQ;
                end
            end
            ST_NSQ: begin
                state_next = ST_NACC;
            end
            ST_NACC: begin
                sumsq_next = sumsq_reg + prod_reg[SUMSQ_W-1:0];
                sum_next   = sum_reg + SUM_W'(nm_reg);
                if (idx_reg == '0 || nm_reg < lo_reg) lo_next = nm_reg;
                if (idx_reg == '0 || nm_reg > hi_reg) hi_next = nm_reg;
                if (last_pt) begin
                    state_next = ST_F0;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            ST_F0: state_next = ST_F1;
            ST_F1: begin
                lhs_next   = prod_reg[LHS_W-1:0];
                state_next = ST_F2;
            end
            ST_F2: begin
                lhs_next   = (lhs_reg >= prod_reg[LHS_W-1:0]) ?
                             lhs_reg - prod_reg[LHS_W-1:0] : '0;
                state_next = ST_F3;
            end
            ST_F3: state_next = ST_F4;
            ST_F4: begin
                res_ok_next = (lhs_reg < prod_reg[LHS_W-1:0]) &&
                              ((hi_reg - lo_reg) <= spread_reg);
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            point_mem[wr_addr] <= (state_reg == ST_IDLE) ?
                                  {s_axis_z, s_axis_y, s_axis_x} : item_reg;
        end
        rd_reg <= point_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= mul_a * mul_b;
        idx_reg   <= idx_next;
        ax_reg    <= ax_next;
        dist_reg  <= dist_next;
        nm_reg    <= nm_next;
        sum_reg   <= sum_next;
        sumsq_reg <= sumsq_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        lhs_reg   <= lhs_next;
        res_out_reg <= res_out_next;
        res_ok_reg  <= res_ok_next;
        if (accept) begin
            cmd_reg  <= s_cmd;
            item_reg <= {s_axis_z, s_axis_y, s_axis_x};
        end
        if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            m_outcome         <= res_out_reg;
            m_quality_ok      <= res_ok_reg;
            m_stored_count    <= count_reg;
            m_violation_count <= viol_reg;
            m_store_full      <= full_reg;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            viol_reg    <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            viol_reg    <= viol_next;
            full_reg    <= full_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_full_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg == (count_reg == CNT_W'(STORE_DEPTH)))
        else $error("full flag disagrees with point count");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("point count past capacity");
    a_root_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_rsp.done |-> state_reg == ST_SQW)
        else $error("square root finished outside its wait state");
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> CNT_W'(idx_reg) < count_reg)
        else $error("point walk beyond stored count");

endmodule

// ===== sv/dpsc_isqrt.sv =====
// dpsc_isqrt: iterative floor square root, one result bit per step from two radicand bits
// depends on dpsc_pkg
module dpsc_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  dpsc_pkg::sqrt_req_t req,
    output dpsc_pkg::sqrt_rsp_t rsp
);
    import dpsc_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [DIST_W-1:0] root_reg, root_next;
    logic [DIST_W-1:0] bit_reg, bit_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIST_W:0]   trial;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.radicand;
            root_next = '0;
            bit_next  = DIST_W'(1) << (DIST_W - 2);
            step_next = STEP_W'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next  = rem_reg - trial[DIST_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg[ROOT_W-1:0];

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("root done without a running pass");
    a_step_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> step_reg == '0)
        else $error("step counter left running");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("start did not begin a pass");

endmodule
